// ===== hw/rtl/acfp_pkg.sv =====
// Shared types, character codes and helper functions of the ASCII CAN frame parser.
package acfp_pkg;

    // Default and upper bound of the number of data bytes in one frame.
    localparam int unsigned ACFP_MAX_BYTES = 8;
    localparam int unsigned ACFP_DATA_W    = 64;
    localparam int unsigned ACFP_ID_W      = 29;

    // Type letters and the digit base.
    localparam logic [7:0] CH_STD_DATA = 8'h74;  // t
    localparam logic [7:0] CH_EXT_DATA = 8'h54;  // T
    localparam logic [7:0] CH_STD_RTR  = 8'h72;  // r
    localparam logic [7:0] CH_EXT_RTR  = 8'h52;  // R
    localparam logic [7:0] CH_ZERO     = 8'h30;  // 0

    // Identifier digit counts and limits.
    localparam logic [3:0] STD_ID_DIGITS = 4'd3;
    localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
    localparam logic [3:0] MAX_LEN_CODE  = 4'd8;
    localparam logic [ACFP_ID_W-1:0] ID_SAT = 29'h1FFF_FFFF;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // One character of the command line.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } acfp_in_t;

    // One parsed frame.
    typedef struct packed {
        logic [ACFP_ID_W-1:0]   frame_id;
        logic                   extended;
        logic                   remote;
        logic [3:0]             request_length;
        logic [3:0]             data_count;
        logic [ACFP_DATA_W-1:0] data_bytes;
        logic [1:0]             status;
    } acfp_out_t;

    // Hex digit value; any other character counts as zero.
    function automatic logic [3:0] acfp_hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        case (c) inside
            [8'h30:8'h39]: v = c - 8'h30;
            [8'h61:8'h66]: v = c - 8'h57;
            [8'h41:8'h46]: v = c - 8'h37;
            default:       v = 8'h00;
        endcase
        return v[3:0];
    endfunction

endpackage

// ===== hw/rtl/acfp_stream_if.sv =====
// Valid/ready stream interface used for the character and frame channels.
interface acfp_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/ascii_can_frame_parser_unit.sv =====
// Top level of the ASCII CAN frame parser: input register, parser core and result register.
//
// Usage: characters of a serial-line CAN command arrive on rx, one per transfer,
// with last set on the final character of the line. The line is a type letter
// (t, T, r, R), the hex identifier, a length digit and the hex data bytes.
// For every line one frame leaves on tx, with a status of ok, unknown type
// letter or line ended early; characters without last produce nothing on tx.
// Path: a character taken on rx is held in the input register and parsed from there;
// the frame of a final character goes into the result register, which offers it on tx.
// Throughput: one character per cycle while no final character waits on a full result
// register, set by the update of the parser state between the input register and the
// result register.
// Stall: the result register holds a frame until tx takes it. While it is full
// and not being taken, a final character waits in the input register and rx
// stops taking characters; all other characters keep flowing.
// Reset: clears the parser state and both valid flags; the first character
// after reset is treated as a type letter.
module ascii_can_frame_parser_unit
    import acfp_pkg::*;
#(
    parameter int unsigned MAX_BYTES = ACFP_MAX_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    acfp_stream_if.sink   rx,
    acfp_stream_if.source tx
);

    acfp_in_t  in_reg;
    logic      in_valid_reg;
    acfp_out_t out_reg;
    logic      out_valid_reg;
    acfp_out_t res;
    logic      proc_fire;

    // A character is parsed unless it ends a line and the result register is blocked.
    assign proc_fire = in_valid_reg && (!in_reg.last || !out_valid_reg || tx.ready);
    assign rx.ready  = !in_valid_reg || proc_fire;

    assign tx.valid   = out_valid_reg;
    assign tx.payload = out_reg;

    acfp_parse_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc_fire),
        .item  (in_reg),
        .res   (res)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_reg <= rx.payload;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_reg.last)
        begin
            out_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // A frame appears only after a final character has been parsed.
    a_frame_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && in_reg.last))
        else $error("frame offered without a final character");

    // A waiting frame is never overwritten by the next line.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc_fire && in_reg.last && out_valid_reg && !tx.ready))
        else $error("pending frame overwritten");

    // A held character blocks new transfers on rx.
    a_hold_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |-> !rx.ready)
        else $error("input register overwritten while held");
`endif

endmodule

// ===== hw/rtl/acfp_parse_core.sv =====
// Parser state and the per-character update, with the frame built from the updated state.
module acfp_parse_core
    import acfp_pkg::*;
#(
    parameter int unsigned MAX_BYTES = ACFP_MAX_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  acfp_in_t  item,
    output acfp_out_t res
);

    localparam int unsigned DW = MAX_BYTES * 8;
    localparam logic [3:0] MAX_BYTES_CODE = 4'(MAX_BYTES);

    typedef enum logic [5:0] {
        PH_TYPE = 6'b000001,
        PH_ID   = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_DONE = 6'b010000,
        PH_BAD  = 6'b100000
    } phase_t;

    phase_t              phase_reg,  phase_next,  upd_phase;
    logic [3:0]          digit_reg,  digit_next,  upd_digit;
    logic [ACFP_ID_W-1:0] id_reg,    id_next,     upd_id;
    logic                ext_reg,    ext_next,    upd_ext;
    logic                rtr_reg,    rtr_next,    upd_rtr;
    logic [3:0]          length_reg, length_next, upd_length;
    logic [DW-1:0]       data_reg,   data_next,   upd_data;
    logic [3:0]          bytes_reg,  bytes_next,  upd_bytes;

    logic [3:0]           hex;
    logic [7:0]           len_raw;
    logic [3:0]           len_val;
    logic [3:0]           digit_inc;
    logic [3:0]           bytes_inc;
    logic [ACFP_ID_W-1:0] id_shift;

    assign hex = acfp_hex_value(item.ch);

    // Effect of one character on the parser state.
    always_comb
    begin
        upd_phase  = phase_reg;
        upd_digit  = digit_reg;
        upd_id     = id_reg;
        upd_ext    = ext_reg;
        upd_rtr    = rtr_reg;
        upd_length = length_reg;
        upd_data   = data_reg;
        upd_bytes  = bytes_reg;
        len_raw    = item.ch - CH_ZERO;
        len_val    = (len_raw > 8'(MAX_LEN_CODE)) ? MAX_LEN_CODE : len_raw[3:0];
        digit_inc  = digit_reg + 4'd1;
        bytes_inc  = bytes_reg + 4'd1;
        id_shift   = (id_reg[ACFP_ID_W-1:ACFP_ID_W-4] != 4'd0) ? ID_SAT
                                                               : {id_reg[ACFP_ID_W-5:0], hex};
        case (phase_reg)
            PH_TYPE:
            begin
                upd_digit = 4'd0;
                upd_id    = '0;
                upd_phase = PH_ID;
                case (item.ch)
                    CH_STD_DATA: begin upd_ext = 1'b0; upd_rtr = 1'b0; end
                    CH_EXT_DATA: begin upd_ext = 1'b1; upd_rtr = 1'b0; end
                    CH_STD_RTR:  begin upd_ext = 1'b0; upd_rtr = 1'b1; end
                    CH_EXT_RTR:  begin upd_ext = 1'b1; upd_rtr = 1'b1; end
                    default:
                    begin
                        upd_digit = digit_reg;
                        upd_id    = id_reg;
                        upd_phase = PH_BAD;
                    end
                endcase
            end
            PH_ID:
            begin
                upd_id    = id_shift;
                upd_digit = digit_inc;
                if (digit_inc >= (ext_reg ? EXT_ID_DIGITS : STD_ID_DIGITS))
                begin
                    // A standard identifier above 11 bits promotes the frame to extended.
                    if (!ext_reg && (id_shift[ACFP_ID_W-1:11] != '0))
                    begin
                        upd_ext = 1'b1;
                    end
                    upd_digit = 4'd0;
                    upd_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (rtr_reg)
                begin
                    upd_length = len_val;
                    upd_phase  = PH_DONE;
                end
                else
                begin
                    upd_length = (len_val > MAX_BYTES_CODE) ? MAX_BYTES_CODE : len_val;
                    upd_bytes  = 4'd0;
                    upd_digit  = 4'd0;
                    upd_data   = '0;
                    upd_phase  = (upd_length == 4'd0) ? PH_DONE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (bytes_reg >= MAX_LEN_CODE)
                begin
                    upd_phase = PH_DONE;
                end
                else
                begin
                    // High nibble first, then low nibble of the current byte lane.
                    for (int i = 0; i < MAX_BYTES; i++)
                    begin
                        if (bytes_reg == 4'(i))
                        begin
                            if (digit_reg == 4'd0)
                            begin
                                upd_data[i*8+4 +: 4] = hex;
                            end
                            else
                            begin
                                upd_data[i*8 +: 4] = hex;
                            end
                        end
                    end
                    if (digit_reg == 4'd0)
                    begin
                        upd_digit = 4'd1;
                    end
                    else
                    begin
                        upd_digit = 4'd0;
                        upd_bytes = bytes_inc;
                        if (bytes_inc >= length_reg)
                        begin
                            upd_phase = PH_DONE;
                        end
                    end
                end
            end
            default:
            begin
                upd_phase = phase_reg;
            end
        endcase
    end

    // Frame built from the updated state; only used on the final character.
    always_comb
    begin
        res = '0;
        case (upd_phase)
            PH_BAD:
            begin
                res.status = ST_BAD_TYPE;
            end
            PH_DONE:
            begin
                res.frame_id = upd_id;
                res.extended = upd_ext;
                res.remote   = upd_rtr;
                if (upd_rtr)
                begin
                    res.request_length = upd_length;
                end
                else
                begin
                    res.data_count = upd_length;
                    res.data_bytes = ACFP_DATA_W'(upd_data);
                end
                res.status = ST_OK;
            end
            PH_ID, PH_LEN, PH_DATA:
            begin
                res.frame_id = (upd_phase == PH_ID) ? '0 : upd_id;
                res.extended = upd_ext;
                res.remote   = upd_rtr;
                res.status   = ST_SHORT;
            end
            default:
            begin
                res.status = ST_SHORT;
            end
        endcase
    end

    // The final character of a line returns the parser to its reset state.
    always_comb
    begin
        phase_next  = phase_reg;
        digit_next  = digit_reg;
        id_next     = id_reg;
        ext_next    = ext_reg;
        rtr_next    = rtr_reg;
        length_next = length_reg;
        data_next   = data_reg;
        bytes_next  = bytes_reg;
        if (step)
        begin
            if (item.last)
            begin
                phase_next  = PH_TYPE;
                digit_next  = 4'd0;
                id_next     = '0;
                ext_next    = 1'b0;
                rtr_next    = 1'b0;
                length_next = 4'd0;
                data_next   = '0;
                bytes_next  = 4'd0;
            end
            else
            begin
                phase_next  = upd_phase;
                digit_next  = upd_digit;
                id_next     = upd_id;
                ext_next    = upd_ext;
                rtr_next    = upd_rtr;
                length_next = upd_length;
                data_next   = upd_data;
                bytes_next  = upd_bytes;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            digit_reg  <= 4'd0;
            id_reg     <= '0;
            ext_reg    <= 1'b0;
            rtr_reg    <= 1'b0;
            length_reg <= 4'd0;
            data_reg   <= '0;
            bytes_reg  <= 4'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            digit_reg  <= digit_next;
            id_reg     <= id_next;
            ext_reg    <= ext_next;
            rtr_reg    <= rtr_next;
            length_reg <= length_next;
            data_reg   <= data_next;
            bytes_reg  <= bytes_next;
        end
    end

`ifndef SYNTHESIS
    // A finished line always leaves the parser waiting for a type letter.
    a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last |=> phase_reg == PH_TYPE)
        else $error("parser not back to type letter after line end");

    // While data is being collected, fewer bytes than the length are complete.
    a_bytes_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> (bytes_reg < length_reg) && (length_reg <= MAX_BYTES_CODE))
        else $error("byte count out of range in data phase");

    // A complete data frame never reports more bytes than the store holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last && (res.status == ST_OK) && !res.remote
        |-> res.data_count <= MAX_BYTES_CODE)
        else $error("data count exceeds store");
`endif

endmodule

// ===== bench/ascii_can_frame_parser_unit_tb.sv =====
// Self-checking testbench of the ASCII CAN frame parser with a predictor of the parsed frames.
`timescale 1ns / 100ps

module ascii_can_frame_parser_unit_tb
    import acfp_pkg::*;
;

    localparam int unsigned MAX_BYTES      = ACFP_MAX_BYTES;
    localparam int          RANDOM_ITEMS   = 1550;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          REPORT_LIMIT   = 10;

    // Character codes used by the hex digit decoder.
    localparam logic [7:0] CH_NINE = 8'h39;  // 9
    localparam logic [7:0] CH_LC_A = 8'h61;  // a
    localparam logic [7:0] CH_LC_F = 8'h66;  // f
    localparam logic [7:0] CH_UC_A = 8'h41;  // A
    localparam logic [7:0] CH_UC_F = 8'h46;  // F

    localparam logic [ACFP_ID_W-1:0] STD_ID_MAX = 29'h7FF;

    typedef enum logic [2:0] {
        PARSE_TYPE,
        PARSE_ID,
        PARSE_LEN,
        PARSE_DATA,
        PARSE_DONE,
        PARSE_BAD
    } parse_phase_t;

    // One queued character; hold makes the sender wait until all frames are out.
    typedef struct packed {
        logic     hold;
        acfp_in_t item;
    } char_slot_t;

    logic clk;
    logic rst_n = 1'b0;

    logic       src_valid  = 1'b0;
    acfp_in_t   src_item   = '0;
    logic       sink_ready = 1'b0;

    acfp_stream_if #(.payload_t(acfp_in_t))  rx_if ();
    acfp_stream_if #(.payload_t(acfp_out_t)) tx_if ();

    assign rx_if.valid   = src_valid;
    assign rx_if.payload = src_item;
    assign tx_if.ready   = sink_ready;

    ascii_can_frame_parser_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if.sink),
        .tx    (tx_if.source)
    );

    char_slot_t pending_chars[$];
    acfp_out_t  frame_q[$];
    int         mismatch_count = 0;

    // Parser state of the predictor.
    parse_phase_t         ps_phase;
    logic [3:0]           ps_digits;
    logic [ACFP_ID_W-1:0] ps_id;
    logic                 ps_ext;
    logic                 ps_rtr;
    logic [3:0]           ps_len;
    logic [63:0]          ps_data;
    logic [3:0]           ps_bytes;
    logic [1:0]           ps_err;

    // Idle drawing state of both sides.
    int   src_wait   = 0;
    int   src_left   = 0;
    bit   src_calm   = 1'b0;
    logic src_valid_nxt;
    acfp_in_t src_item_nxt;
    int   sink_wait  = 0;
    int   sink_left  = 0;
    bit   sink_calm  = 1'b0;
    logic sink_ready_nxt;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles for one transfer, with occasional stretches of none at all.
    function automatic int draw_idle(inout int left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(16, 96);
            calm = ($urandom_range(0, 3) == 0);
        end
        left = left - 1;
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = c - CH_ZERO;
        else if (c >= CH_LC_A && c <= CH_LC_F)
            v = c - CH_LC_A + 8'd10;
        else if (c >= CH_UC_A && c <= CH_UC_F)
            v = c - CH_UC_A + 8'd10;
        return v[3:0];
    endfunction

    task automatic clear_parser();
        ps_phase  = PARSE_TYPE;
        ps_digits = '0;
        ps_id     = '0;
        ps_ext    = 1'b0;
        ps_rtr    = 1'b0;
        ps_len    = '0;
        ps_data   = '0;
        ps_bytes  = '0;
        ps_err    = ST_OK;
    endtask

    // Advances the predicted parser by one character; a final character yields a frame.
    task automatic parse_char(input acfp_in_t in);
        logic [7:0]  c;
        logic [7:0]  n;
        logic [32:0] wide;
        acfp_out_t   res;
        c   = in.ch;
        res = '0;
        case (ps_phase)
            PARSE_TYPE:
            begin
                if (c == CH_STD_DATA || c == CH_EXT_DATA || c == CH_STD_RTR || c == CH_EXT_RTR)
                begin
                    ps_ext    = (c == CH_EXT_DATA || c == CH_EXT_RTR);
                    ps_rtr    = (c == CH_STD_RTR || c == CH_EXT_RTR);
                    ps_digits = '0;
                    ps_id     = '0;
                    ps_phase  = PARSE_ID;
                end
                else
                begin
                    ps_err   = ST_BAD_TYPE;
                    ps_phase = PARSE_BAD;
                end
            end
            PARSE_ID:
            begin
                // The identifier saturates rather than wrapping.
                wide = {ps_id, nibble_of(c)};
                ps_id = (wide > {4'h0, ID_SAT}) ? ID_SAT : wide[ACFP_ID_W-1:0];
                ps_digits = ps_digits + 4'd1;
                if (ps_digits >= (ps_ext ? EXT_ID_DIGITS : STD_ID_DIGITS))
                begin
                    if (!ps_ext && ps_id > STD_ID_MAX)
                        ps_ext = 1'b1;
                    ps_digits = '0;
                    ps_phase  = PARSE_LEN;
                end
            end
            PARSE_LEN:
            begin
                n = c - CH_ZERO;
                if (n > {4'h0, MAX_LEN_CODE})
                    n = {4'h0, MAX_LEN_CODE};
                if (ps_rtr)
                begin
                    ps_len   = n[3:0];
                    ps_phase = PARSE_DONE;
                end
                else
                begin
                    if (n > 8'(MAX_BYTES))
                        n = 8'(MAX_BYTES);
                    ps_len    = n[3:0];
                    ps_bytes  = '0;
                    ps_digits = '0;
                    ps_data   = '0;
                    ps_phase  = (n == 8'd0) ? PARSE_DONE : PARSE_DATA;
                end
            end
            PARSE_DATA:
            begin
                if (ps_bytes >= MAX_LEN_CODE)
                    ps_phase = PARSE_DONE;
                else if (ps_digits == 4'd0)
                begin
                    ps_data   = ps_data | ({60'h0, nibble_of(c)} << (8 * ps_bytes + 4));
                    ps_digits = 4'd1;
                end
                else
                begin
                    ps_data   = ps_data | ({60'h0, nibble_of(c)} << (8 * ps_bytes));
                    ps_digits = '0;
                    ps_bytes  = ps_bytes + 4'd1;
                    if (ps_bytes >= ps_len)
                        ps_phase = PARSE_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (in.last)
        begin
            if (ps_phase == PARSE_BAD || ps_err != ST_OK)
                res.status = ST_BAD_TYPE;
            else if (ps_phase == PARSE_DONE)
            begin
                res.frame_id = ps_id;
                res.extended = ps_ext;
                res.remote   = ps_rtr;
                if (ps_rtr)
                    res.request_length = ps_len;
                else
                begin
                    res.data_count = ps_len;
                    res.data_bytes = ps_data;
                end
                res.status = ST_OK;
            end
            else if (ps_phase == PARSE_TYPE)
                res.status = ST_SHORT;
            else
            begin
                // A line cut short keeps the identifier only once it is complete.
                res.frame_id = (ps_phase == PARSE_ID) ? '0 : ps_id;
                res.extended = ps_ext;
                res.remote   = ps_rtr;
                res.status   = ST_SHORT;
            end
            frame_q.insert(frame_q.size(), res);
            clear_parser();
        end
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    task automatic check_frame(input acfp_out_t got);
        acfp_out_t want;
        if (frame_q.size() == 0)
        begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected frame: %h", got);
        end
        else
        begin
            want = frame_q.pop_front();
            report_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
            report_field("extended", 64'(want.extended), 64'(got.extended));
            report_field("remote", 64'(want.remote), 64'(got.remote));
            report_field("request_length", 64'(want.request_length), 64'(got.request_length));
            report_field("data_count", 64'(want.data_count), 64'(got.data_count));
            report_field("data_bytes", want.data_bytes, got.data_bytes);
            report_field("status", 64'(want.status), 64'(got.status));
        end
    endtask

    // Queues one command line; the final character carries the last mark.
    task automatic queue_line(input logic [7:0] line_q[$], input bit hold);
        char_slot_t slot;
        for (int i = 0; i < line_q.size(); i++)
        begin
            slot.hold      = hold && (i == 0);
            slot.item.ch   = line_q[i];
            slot.item.last = (i == line_q.size() - 1);
            pending_chars.insert(pending_chars.size(), slot);
        end
    endtask

    task automatic queue_text(input string s);
        logic [7:0] line_q[$];
        for (int i = 0; i < s.len(); i++)
            line_q.insert(line_q.size(), 8'(s[i]));
        queue_line(line_q, 1'b0);
    endtask

    function automatic logic [7:0] random_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'(digits[$urandom_range(0, 21)]);
    endfunction

    // Builds one random line: mostly well-formed frames, some cut short,
    // some with trailing characters and some plain noise.
    task automatic queue_random_line(input bit hold);
        logic [7:0] line_q[$];
        logic [7:0] letter;
        logic [7:0] len_ch;
        logic [7:0] n;
        int         kind;
        int         cut;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6))
                line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       letter = CH_STD_DATA;
                1:       letter = CH_EXT_DATA;
                2:       letter = CH_STD_RTR;
                default: letter = CH_EXT_RTR;
            endcase
            line_q.insert(line_q.size(), letter);
            repeat ((letter == CH_EXT_DATA || letter == CH_EXT_RTR) ? 8 : 3)
                line_q.insert(line_q.size(), random_hex_char());
            if ($urandom_range(0, 9) == 0)
                len_ch = 8'($urandom_range(0, 255));
            else
                len_ch = CH_ZERO + 8'($urandom_range(0, 8));
            line_q.insert(line_q.size(), len_ch);
            if (letter == CH_STD_DATA || letter == CH_EXT_DATA)
            begin
                n = len_ch - CH_ZERO;
                if (n > 8'(MAX_BYTES))
                    n = 8'(MAX_BYTES);
                repeat (2 * n)
                    line_q.insert(line_q.size(), random_hex_char());
            end
            if (kind < 25)
            begin
                cut = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > cut)
                    void'(line_q.pop_back());
            end
            else if (kind < 35)
            begin
                repeat ($urandom_range(1, 3))
                    line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
            end
        end
        queue_line(line_q, hold);
    endtask

    // Sender: presents queued characters and predicts on every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item  <= '0;
            src_wait   = 0;
            clear_parser();
        end
        else
        begin
            src_valid_nxt = src_valid;
            src_item_nxt  = src_item;
            if (src_valid && rx_if.ready)
            begin
                parse_char(src_item);
                src_valid_nxt = 1'b0;
                src_wait      = draw_idle(src_left, src_calm);
            end
            if (!src_valid_nxt)
            begin
                if (src_wait > 0)
                    src_wait = src_wait - 1;
                else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].hold && frame_q.size() != 0))
                begin
                    src_item_nxt  = pending_chars[0].item;
                    src_valid_nxt = 1'b1;
                    void'(pending_chars.pop_front());
                end
            end
            src_valid <= src_valid_nxt;
            src_item  <= src_item_nxt;
        end
    end

    // Receiver: stalls at random and checks every frame transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            sink_wait   = 0;
        end
        else
        begin
            sink_ready_nxt = sink_ready;
            if (tx_if.valid && sink_ready)
            begin
                check_frame(tx_if.payload);
                sink_wait      = draw_idle(sink_left, sink_calm);
                sink_ready_nxt = (sink_wait == 0);
            end
            else if (!sink_ready)
            begin
                if (sink_wait > 0)
                    sink_wait = sink_wait - 1;
                sink_ready_nxt = (sink_wait == 0);
            end
            sink_ready <= sink_ready_nxt;
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int target;
        logic [7:0] line_q[$];

        // Standard ID above the standard range, data length zero.
        queue_text("t8000");
        // Extended remote with a saturating ID and a length digit far out of range.
        queue_text("RFFFFFFFF\377");
        // Unknown type letter on a single character.
        line_q.insert(line_q.size(), 8'h00);
        queue_line(line_q, 1'b0);
        // Mixed-case data byte followed by a character after the complete frame.
        queue_text("t12a1aBz");
        // Non-hex ID digit and a line ended early within the ID.
        queue_text("t1g");

        target = pending_chars.size() + RANDOM_ITEMS;
        queue_random_line(1'b1);
        while (pending_chars.size() < target)
            queue_random_line($urandom_range(0, 24) == 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || src_valid || frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && frame_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/acfp_pkg.sv
hw/rtl/acfp_stream_if.sv
hw/rtl/acfp_parse_core.sv
hw/rtl/ascii_can_frame_parser_unit.sv
bench/ascii_can_frame_parser_unit_tb.sv
